// ----- sv/sql_string_literal_unescaper_macros.svh -----
// assertion macros shared by the unescaper modules
// expects aclk and aresetn in the scope of each use
`ifndef SQL_STRING_LITERAL_UNESCAPER_MACROS_SVH
`define SQL_STRING_LITERAL_UNESCAPER_MACROS_SVH

// same-cycle implication, off during reset
`define SSLU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sslu assertion failed");

// next-cycle implication, off during reset
`define SSLU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sslu assertion failed");

`endif

// ----- sv/sslu_pkg.sv -----
// types, constants and helpers for the sql string literal unescaper
// no dependencies
package sslu_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = QPTR_BITS + 1;

    localparam logic [7:0] CHR_BACKSLASH  = 8'h5C;
    localparam logic [7:0] CHR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHR_PERCENT    = 8'h25;
    localparam logic [7:0] CHR_LF         = 8'h0A;
    localparam logic [7:0] CHR_TAB        = 8'h09;
    localparam logic [7:0] CHR_CR         = 8'h0D;
    localparam logic [7:0] CHR_BS         = 8'h08;
    localparam logic [7:0] CHR_NUL        = 8'h00;
    localparam logic [7:0] CHR_SUB        = 8'h1A;
    localparam logic [7:0] CHR_N          = 8'h6E;
    localparam logic [7:0] CHR_T          = 8'h74;
    localparam logic [7:0] CHR_R          = 8'h72;
    localparam logic [7:0] CHR_B          = 8'h62;
    localparam logic [7:0] CHR_ZERO       = 8'h30;
    localparam logic [7:0] CHR_Z          = 8'h5A;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERROR = 2'd2
    } sslu_kind_t;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_PAIR  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_ERROR = 2'd3
    } sslu_op_t;

    typedef struct packed {
        sslu_op_t    op;
        logic [7:0]  data;
        logic [15:0] length;
    } sslu_entry_t;

    typedef struct packed {
        logic        valid;
        sslu_entry_t entry;
    } sslu_push_t;

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CHR_N:    r = CHR_LF;
            CHR_T:    r = CHR_TAB;
            CHR_R:    r = CHR_CR;
            CHR_B:    r = CHR_BS;
            CHR_ZERO: r = CHR_NUL;
            CHR_Z:    r = CHR_SUB;
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_inc(input logic [LENGTH_BITS-1:0] v);
        logic [LENGTH_BITS-1:0] r;
        r = (v == {LENGTH_BITS{1'b1}}) ? v : v + LENGTH_BITS'(1);
        return r;
    endfunction

    function automatic logic [15:0] clip_length(input logic [LENGTH_BITS-1:0] v);
        logic [32:0] w;
        logic [15:0] r;
        w = 33'(v);
        r = (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
        return r;
    endfunction

endpackage

// ----- sv/sslu_front.sv -----
// front end: accepts input bytes, tracks literal state, classifies into queue ops
// depends on sslu_pkg
module sslu_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_start_req,
    input  logic               s_end_of_input,
    input  logic               queue_full,
    output sslu_pkg::sslu_push_t push
);
    import sslu_pkg::*;

    logic [7:0]             quote_reg, quote_next;
    logic                   inside_reg, inside_next;
    logic                   esc_reg, esc_next;
    logic                   qpend_reg, qpend_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   accept;
    logic [LENGTH_BITS-1:0] count_p1, count_p2;
    logic                   close_ok;

    assign s_ready  = !queue_full;
    assign accept   = s_valid && s_ready;
    assign count_p1 = sat_inc(count_reg);
    assign count_p2 = sat_inc(count_p1);
    assign close_ok = qpend_reg && !esc_reg;

    always_comb begin
        quote_next  = quote_reg;
        inside_next = inside_reg;
        esc_next    = esc_reg;
        qpend_next  = qpend_reg;
        count_next  = count_reg;
        push        = '0;
        if (accept) begin
            priority if (s_end_of_input || s_start_req) begin
                if (inside_reg) begin
                    push.valid        = 1'b1;
                    push.entry.op     = close_ok ? OP_CLOSE : OP_ERROR;
                    push.entry.length = close_ok ? clip_length(count_reg) : 16'd0;
                end
                esc_next   = 1'b0;
                qpend_next = 1'b0;
                if (s_end_of_input) begin
                    inside_next = 1'b0;
                end else begin
                    quote_next  = s_data_byte;
                    inside_next = 1'b1;
                    count_next  = '0;
                end
            end else if (inside_reg) begin
                priority if (esc_reg) begin
                    esc_next   = 1'b0;
                    push.valid = 1'b1;
                    if (s_data_byte == CHR_UNDERSCORE || s_data_byte == CHR_PERCENT) begin
                        push.entry.op   = OP_PAIR;
                        push.entry.data = s_data_byte;
                        count_next      = count_p2;
                    end else begin
                        push.entry.op   = OP_BYTE;
                        push.entry.data = map_escape(s_data_byte);
                        count_next      = count_p1;
                    end
                end else if (qpend_reg) begin
                    push.valid = 1'b1;
                    if (s_data_byte == quote_reg) begin
                        qpend_next      = 1'b0;
                        push.entry.op   = OP_BYTE;
                        push.entry.data = s_data_byte;
                        count_next      = count_p1;
                    end else begin
                        push.entry.op     = OP_CLOSE;
                        push.entry.length = clip_length(count_reg);
                        inside_next       = 1'b0;
                        qpend_next        = 1'b0;
                    end
                end else if (s_data_byte == CHR_BACKSLASH) begin
                    esc_next = 1'b1;
                end else if (s_data_byte == quote_reg) begin
                    qpend_next = 1'b1;
                end else begin
                    push.valid      = 1'b1;
                    push.entry.op   = OP_BYTE;
                    push.entry.data = s_data_byte;
                    count_next      = count_p1;
                end
            end else begin
                // idle byte dropped
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_reg  <= '0;
            inside_reg <= 1'b0;
            esc_reg    <= 1'b0;
            qpend_reg  <= 1'b0;
            count_reg  <= '0;
        end else begin
            quote_reg  <= quote_next;
            inside_reg <= inside_next;
            esc_reg    <= esc_next;
            qpend_reg  <= qpend_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/sslu_queue.sv -----
// small op queue between the front end and the result generator
// depends on sslu_pkg and the assertion macro header
`include "sql_string_literal_unescaper_macros.svh"
module sslu_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sslu_pkg::sslu_push_t  push,
    output logic                  full,
    output logic                  head_valid,
    output sslu_pkg::sslu_entry_t head_entry,
    input  logic                  pop
);
    import sslu_pkg::*;

    sslu_entry_t            mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, wr_next;
    logic [QPTR_BITS-1:0]   rd_reg, rd_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   do_push, do_pop;

    assign full       = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? wr_reg + QPTR_BITS'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_BITS'(1) : rd_reg;
        cnt_next = cnt_reg + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    `SSLU_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_reg <= QCNT_BITS'(QDEPTH))
    `SSLU_ASSERT_IMPL(a_no_lost_push, push.valid, !full)
    `SSLU_ASSERT_IMPL(a_ptr_gap, 1'b1, (wr_reg - rd_reg) == cnt_reg[QPTR_BITS-1:0])

endmodule

// ----- sv/sslu_back.sv -----
// back end: expands queue ops into result transfers through an output register
// depends on sslu_pkg and the assertion macro header
`include "sql_string_literal_unescaper_macros.svh"
module sslu_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  sslu_pkg::sslu_entry_t head_entry,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic [1:0]            m_kind,
    output logic [15:0]           m_content_length,
    output logic                  m_last
);
    import sslu_pkg::*;

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    sslu_kind_t  kind_reg, kind_next;
    logic [15:0] len_reg, len_next;
    logic        last_reg, last_next;
    logic        load;

    assign load = head_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg && !m_ready;
        phase_next = phase_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = 1'b1;
            len_next   = 16'd0;
            byte_next  = 8'd0;
            last_next  = 1'b1;
            unique case (head_entry.op)
                OP_BYTE: begin
                    kind_next = KIND_BYTE;
                    byte_next = head_entry.data;
                    pop       = 1'b1;
                end
                OP_PAIR: begin
                    kind_next = KIND_BYTE;
                    if (!phase_reg) begin
                        byte_next  = CHR_BACKSLASH;
                        last_next  = 1'b0;
                        phase_next = 1'b1;
                    end else begin
                        byte_next  = head_entry.data;
                        phase_next = 1'b0;
                        pop        = 1'b1;
                    end
                end
                OP_CLOSE: begin
                    kind_next = KIND_CLOSE;
                    len_next  = head_entry.length;
                    pop       = 1'b1;
                end
                OP_ERROR: begin
                    kind_next = KIND_ERROR;
                    pop       = 1'b1;
                end
                default: begin
                    kind_next = KIND_ERROR;
                    pop       = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        len_reg  <= len_next;
        last_reg <= last_next;
    end

    assign m_valid          = valid_reg;
    assign m_out_byte       = byte_reg;
    assign m_kind           = kind_reg;
    assign m_content_length = len_reg;
    assign m_last           = last_reg;

    `SSLU_ASSERT_IMPL(a_phase_on_pair, phase_reg, head_valid && head_entry.op == OP_PAIR)
    `SSLU_ASSERT_IMPL(a_split_is_backslash, valid_reg && !last_reg,
                      byte_reg == CHR_BACKSLASH && kind_reg == KIND_BYTE && phase_reg)
    `SSLU_ASSERT_NEXT(a_pair_second_half, load && head_entry.op == OP_PAIR && !phase_reg,
                      valid_reg && !last_reg)

endmodule

// ----- sv/sql_string_literal_unescaper.sv -----
// Unescapes a quoted SQL text literal presented one byte per transfer. An input
// transfer is taken whenever s_ready is high; a front end updates the literal state
// and queues at most one op per byte into a four-entry queue, and a back end turns
// each op into one result transfer, or two for a backslash kept before _ or %,
// through an output register, at one per cycle while m_ready is high. Sustained rate
// is one input byte per cycle while the result side takes a transfer every cycle;
// s_ready drops only when the queue is full; ops pass the queue and output register.
// depends on sslu_pkg, sslu_front, sslu_queue and sslu_back
module sql_string_literal_unescaper (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    input  logic        s_end_of_input,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_kind,
    output logic [15:0] m_content_length,
    output logic        m_last
);
    import sslu_pkg::*;

    sslu_push_t  push;
    logic        queue_full;
    logic        head_valid;
    sslu_entry_t head_entry;
    logic        pop;

    sslu_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_start_req    (s_start_req),
        .s_end_of_input (s_end_of_input),
        .queue_full     (queue_full),
        .push           (push)
    );

    sslu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop)
    );

    sslu_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (head_valid),
        .head_entry       (head_entry),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_kind           (m_kind),
        .m_content_length (m_content_length),
        .m_last           (m_last)
    );

endmodule
